[rtl/qph_pkg.sv]
// Shared types and constants for the quadratic probe hash table core.
`timescale 1ns / 1ps
package qph_pkg;

    localparam int KEY_W      = 64;
    localparam int VAL_W      = 64;
    localparam int CNT_W      = 10;
    localparam int SLOT_OUT_W = 10;
    localparam int MULT_W     = 30;
    localparam int PROD_W     = 62;

    localparam logic [MULT_W-1:0] HASH_MULT = 30'd536870909;
    localparam logic [CNT_W-1:0]  CAP_RESET = 10'd714;

    localparam logic [1:0] FLAGS_FREE = 2'b00;
    localparam logic [1:0] FLAGS_OCC  = 2'b01;
    localparam logic [1:0] FLAGS_TOMB = 2'b10;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_NO_ROOM   = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_INIT_CLR,
        S_IDLE,
        S_DISPATCH,
        S_HASH,
        S_ADDR,
        S_READ,
        S_EVAL,
        S_CLEAR,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic    load_item;
        logic    hash_start;
        logic    probe_init;
        logic    probe_step;
        logic    write_insert;
        logic    write_remove;
        logic    clear_step;
        logic    count_clr;
        logic    count_inc;
        logic    count_dec;
        logic    out_load;
        logic    out_slot_en;
        logic    out_value_en;
        status_t out_status;
    } cmd_t;

    typedef struct packed {
        op_t  opcode;
        logic hash_done;
        logic occ;
        logic tomb;
        logic key_match;
        logic exhausted;
        logic clear_last;
        logic count_full;
        logic out_free;
    } stat_t;

endpackage

[rtl/qph_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module qph_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1021
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/qph_hash.sv]
// Home slot unit: key times constant, fold halves, residue fold and reciprocal reduction.
`timescale 1ns / 1ps
module qph_hash #(
    parameter int TABLE_SLOTS = 1021
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [qph_pkg::KEY_W-1:0]      key,
    output logic                           done,
    output logic [$clog2(TABLE_SLOTS)-1:0] home
);

    localparam int SW  = $clog2(TABLE_SLOTS);
    localparam int PW  = qph_pkg::PROD_W;
    localparam int NCH = (64 + SW - 1) / SW;
    localparam int ZW  = 2 * SW + $clog2(NCH);
    localparam int AW  = ZW - SW + 1;
    localparam int BW  = 2 * AW;
    localparam logic [AW-1:0] MU = AW'((64'd1 << ZW) / 64'(TABLE_SLOTS));

    function automatic longint unsigned chunk_res(int idx);
        longint unsigned r;
        r = 64'd1 % 64'(TABLE_SLOTS);
        for (int n = 0; n < idx * SW; n++)
        begin
            r = (r * 64'd2) % 64'(TABLE_SLOTS);
        end
        return r;
    endfunction

    logic [PW-1:0] p0_reg;
    logic [PW-1:0] p1_reg;
    logic [63:0]   x_reg;
    logic [ZW-1:0] z_reg;
    logic [AW-1:0] q_reg;
    logic [SW+1:0] r_reg;
    logic [SW-1:0] home_reg;
    logic          mul_v_reg;
    logic          x_v_reg;
    logic          z_v_reg;
    logic          q_v_reg;
    logic          r_v_reg;
    logic          done_reg;

    logic [64:0]   lo_sum;
    logic [63:0]   hi_word;
    logic [ZW-1:0] part [NCH];
    logic [ZW-1:0] fold_sum;
    logic [BW-1:0] q_prod;
    logic [ZW-1:0] diff;
    logic [SW+1:0] r1;
    logic [SW+1:0] r2;

    for (genvar g = 0; g < NCH; g++)
    begin : g_fold
        localparam logic [SW-1:0] RES = SW'(chunk_res(g));
        localparam int LO = g * SW;
        localparam int HI = (g * SW + SW - 1 > 63) ? 63 : g * SW + SW - 1;
        logic [SW-1:0] chunk;
        assign chunk   = SW'(x_reg[HI:LO]);
        assign part[g] = ZW'(chunk) * ZW'(RES);
    end

    always_comb
    begin
        lo_sum   = {1'b0, 64'(p0_reg)} + {1'b0, p1_reg[31:0], 32'h0};
        hi_word  = 64'(p1_reg[PW-1:32]) + 64'(lo_sum[64]);
        fold_sum = '0;
        for (int c = 0; c < NCH; c++)
        begin
            fold_sum = fold_sum + part[c];
        end
        q_prod = BW'(z_reg[ZW-1:SW-1]) * BW'(MU);
        diff   = z_reg - ZW'(q_reg) * ZW'(TABLE_SLOTS);
        r1     = (r_reg >= (SW+2)'(TABLE_SLOTS)) ? r_reg - (SW+2)'(TABLE_SLOTS) : r_reg;
        r2     = (r1 >= (SW+2)'(TABLE_SLOTS)) ? r1 - (SW+2)'(TABLE_SLOTS) : r1;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            p0_reg <= PW'(key[31:0]) * PW'(qph_pkg::HASH_MULT);
            p1_reg <= PW'(key[63:32]) * PW'(qph_pkg::HASH_MULT);
        end
        x_reg <= hi_word ^ lo_sum[63:0];
        z_reg <= fold_sum;
        q_reg <= q_prod[BW-1:AW];
        r_reg <= diff[SW+1:0];
        if (r_v_reg)
        begin
            home_reg <= r2[SW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_v_reg <= 1'b0;
            x_v_reg   <= 1'b0;
            z_v_reg   <= 1'b0;
            q_v_reg   <= 1'b0;
            r_v_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            mul_v_reg <= start;
            x_v_reg   <= mul_v_reg;
            z_v_reg   <= x_v_reg;
            q_v_reg   <= z_v_reg;
            r_v_reg   <= q_v_reg;
            if (start)
            begin
                done_reg <= 1'b0;
            end
            else if (r_v_reg)
            begin
                done_reg <= 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign home = home_reg;

endmodule

[rtl/qph_datapath.sv]
// Datapath: item registers, hash unit, probe sequence, table memories, counters, result word.
`timescale 1ns / 1ps
module qph_datapath #(
    parameter int TABLE_SLOTS = 1021
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  qph_pkg::cmd_t                   cmd,
    output qph_pkg::stat_t                  stat,
    input  logic [1:0]                      in_opcode,
    input  logic [qph_pkg::KEY_W-1:0]       in_key,
    input  logic [qph_pkg::VAL_W-1:0]       in_value,
    input  logic                            cap_we,
    input  logic [qph_pkg::CNT_W-1:0]       cap_wdata,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [1:0]                      out_status,
    output logic [qph_pkg::VAL_W-1:0]       out_value,
    output logic [qph_pkg::SLOT_OUT_W-1:0]  out_slot
);

    localparam int SW = $clog2(TABLE_SLOTS);
    localparam int JW = $clog2(TABLE_SLOTS + 1);

    qph_pkg::op_t                opcode_reg;
    logic [qph_pkg::KEY_W-1:0]   key_reg;
    logic [qph_pkg::VAL_W-1:0]   value_reg;
    logic [SW-1:0]               sq_reg;
    logic [SW-1:0]               d_reg;
    logic [JW-1:0]               j_reg;
    logic [SW-1:0]               slot_reg;
    logic [SW-1:0]               clr_cnt_reg;
    logic [qph_pkg::CNT_W-1:0]   count_reg;
    logic [qph_pkg::CNT_W-1:0]   cap_reg;
    logic                        out_valid_reg;
    logic [1:0]                  out_status_reg;
    logic [qph_pkg::VAL_W-1:0]   out_value_reg;
    logic [SW-1:0]               out_slot_reg;

    logic                        hash_done;
    logic [SW-1:0]               home;
    logic [SW:0]                 sum_sq;
    logic [SW:0]                 sum_d;
    logic [SW:0]                 fwd;
    logic [SW:0]                 bwd;
    logic [SW-1:0]               slot_calc;
    logic [SW-1:0]               ram_addr;
    logic                        flag_we;
    logic [1:0]                  flag_wdata;
    logic [1:0]                  flag_rd;
    logic [qph_pkg::KEY_W-1:0]   key_rd;
    logic [qph_pkg::VAL_W-1:0]   value_rd;

    qph_hash #(.TABLE_SLOTS(TABLE_SLOTS)) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.hash_start),
        .key   (key_reg),
        .done  (hash_done),
        .home  (home)
    );

    always_comb
    begin
        sum_sq = {1'b0, sq_reg} + {1'b0, d_reg};
        if (sum_sq >= (SW+1)'(TABLE_SLOTS))
        begin
            sum_sq = sum_sq - (SW+1)'(TABLE_SLOTS);
        end
        sum_d = {1'b0, d_reg} + (SW+1)'(2);
        if (sum_d >= (SW+1)'(TABLE_SLOTS))
        begin
            sum_d = sum_d - (SW+1)'(TABLE_SLOTS);
        end
        fwd = {1'b0, home} + {1'b0, sq_reg};
        if (fwd >= (SW+1)'(TABLE_SLOTS))
        begin
            fwd = fwd - (SW+1)'(TABLE_SLOTS);
        end
        if (home >= sq_reg)
        begin
            bwd = {1'b0, home} - {1'b0, sq_reg};
        end
        else
        begin
            bwd = {1'b0, home} + (SW+1)'(TABLE_SLOTS) - {1'b0, sq_reg};
        end
        slot_calc = j_reg[0] ? fwd[SW-1:0] : bwd[SW-1:0];
    end

    always_comb
    begin
        ram_addr   = cmd.clear_step ? clr_cnt_reg : slot_reg;
        flag_we    = cmd.clear_step || cmd.write_insert || cmd.write_remove;
        flag_wdata = qph_pkg::FLAGS_FREE;
        if (cmd.write_insert)
        begin
            flag_wdata = qph_pkg::FLAGS_OCC;
        end
        else if (cmd.write_remove)
        begin
            flag_wdata = qph_pkg::FLAGS_TOMB;
        end
    end

    qph_ram #(.WIDTH(2), .DEPTH(TABLE_SLOTS)) u_flag_ram (
        .clk   (clk),
        .we    (flag_we),
        .waddr (ram_addr),
        .wdata (flag_wdata),
        .raddr (ram_addr),
        .rdata (flag_rd)
    );

    qph_ram #(.WIDTH(qph_pkg::KEY_W), .DEPTH(TABLE_SLOTS)) u_key_ram (
        .clk   (clk),
        .we    (cmd.write_insert),
        .waddr (ram_addr),
        .wdata (key_reg),
        .raddr (ram_addr),
        .rdata (key_rd)
    );

    qph_ram #(.WIDTH(qph_pkg::VAL_W), .DEPTH(TABLE_SLOTS)) u_value_ram (
        .clk   (clk),
        .we    (cmd.write_insert),
        .waddr (ram_addr),
        .wdata (value_reg),
        .raddr (ram_addr),
        .rdata (value_rd)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            opcode_reg <= qph_pkg::op_t'(in_opcode);
            key_reg    <= in_key;
            value_reg  <= in_value;
        end
        if (cmd.probe_step)
        begin
            slot_reg <= slot_calc;
            sq_reg   <= sum_sq[SW-1:0];
            d_reg    <= sum_d[SW-1:0];
        end
        else if (cmd.probe_init)
        begin
            sq_reg <= '0;
            d_reg  <= SW'(1);
        end
        if (cmd.out_load)
        begin
            out_status_reg <= cmd.out_status;
            out_value_reg  <= cmd.out_value_en ? value_rd : '0;
            out_slot_reg   <= cmd.out_slot_en ? slot_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_reg         <= '0;
            clr_cnt_reg   <= '0;
            count_reg     <= '0;
            cap_reg       <= qph_pkg::CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.probe_step)
            begin
                j_reg <= j_reg + JW'(1);
            end
            else if (cmd.probe_init)
            begin
                j_reg <= '0;
            end
            if (cmd.clear_step)
            begin
                clr_cnt_reg <= (clr_cnt_reg == SW'(TABLE_SLOTS - 1)) ? '0 : clr_cnt_reg + SW'(1);
            end
            if (cmd.count_clr)
            begin
                count_reg <= '0;
            end
            else if (cmd.count_inc)
            begin
                count_reg <= count_reg + qph_pkg::CNT_W'(1);
            end
            else if (cmd.count_dec)
            begin
                count_reg <= count_reg - qph_pkg::CNT_W'(1);
            end
            if (cap_we)
            begin
                cap_reg <= cap_wdata;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        stat.opcode     = opcode_reg;
        stat.hash_done  = hash_done;
        stat.occ        = flag_rd[0];
        stat.tomb       = flag_rd[1];
        stat.key_match  = (key_rd == key_reg);
        stat.exhausted  = (j_reg == JW'(TABLE_SLOTS));
        stat.clear_last = (clr_cnt_reg == SW'(TABLE_SLOTS - 1));
        stat.count_full = (count_reg >= cap_reg);
        stat.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_value  = out_value_reg;
    assign out_slot   = qph_pkg::SLOT_OUT_W'(out_slot_reg);

endmodule

[rtl/qph_ctrl.sv]
// Controller: sequences dispatch, hashing, probe walk, clear sweep and result hand-off.
`timescale 1ns / 1ps
module qph_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  qph_pkg::stat_t stat,
    output qph_pkg::cmd_t  cmd
);

    qph_pkg::state_t  state_reg;
    qph_pkg::state_t  state_next;
    qph_pkg::status_t res_status_reg;
    qph_pkg::status_t res_status_next;
    logic             res_slot_reg;
    logic             res_slot_next;
    logic             res_value_reg;
    logic             res_value_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= qph_pkg::S_INIT_CLR;
            res_status_reg <= qph_pkg::ST_OK;
            res_slot_reg   <= 1'b0;
            res_value_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            res_status_reg <= res_status_next;
            res_slot_reg   <= res_slot_next;
            res_value_reg  <= res_value_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_value_next  = res_value_reg;
        cmd             = '0;
        cmd.out_status  = res_status_reg;
        cmd.out_slot_en = res_slot_reg;
        cmd.out_value_en = res_value_reg;
        in_ready        = 1'b0;
        case (state_reg)
            qph_pkg::S_INIT_CLR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = qph_pkg::S_IDLE;
                end
            end
            qph_pkg::S_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
                if (in_valid)
                begin
                    state_next = qph_pkg::S_DISPATCH;
                end
            end
            qph_pkg::S_DISPATCH:
            begin
                res_status_next = qph_pkg::ST_OK;
                res_slot_next   = 1'b0;
                res_value_next  = 1'b0;
                if (stat.opcode == qph_pkg::OP_CLEAR)
                begin
                    state_next = qph_pkg::S_CLEAR;
                end
                else if (stat.opcode == qph_pkg::OP_INSERT && stat.count_full)
                begin
                    res_status_next = qph_pkg::ST_NO_ROOM;
                    state_next      = qph_pkg::S_RESULT;
                end
                else
                begin
                    cmd.hash_start = 1'b1;
                    state_next     = qph_pkg::S_HASH;
                end
            end
            qph_pkg::S_HASH:
            begin
                cmd.probe_init = 1'b1;
                if (stat.hash_done)
                begin
                    state_next = qph_pkg::S_ADDR;
                end
            end
            qph_pkg::S_ADDR:
            begin
                cmd.probe_step = 1'b1;
                state_next     = qph_pkg::S_READ;
            end
            qph_pkg::S_READ:
            begin
                state_next = qph_pkg::S_EVAL;
            end
            qph_pkg::S_EVAL:
            begin
                state_next = qph_pkg::S_RESULT;
                if (stat.opcode == qph_pkg::OP_INSERT)
                begin
                    if (!stat.occ)
                    begin
                        cmd.write_insert = 1'b1;
                        cmd.count_inc    = 1'b1;
                        res_slot_next    = 1'b1;
                    end
                    else if (stat.key_match)
                    begin
                        res_status_next = qph_pkg::ST_DUPLICATE;
                        res_slot_next   = 1'b1;
                    end
                    else if (stat.exhausted)
                    begin
                        res_status_next = qph_pkg::ST_NO_ROOM;
                    end
                    else
                    begin
                        state_next = qph_pkg::S_ADDR;
                    end
                end
                else
                begin
                    if (!stat.occ && !stat.tomb)
                    begin
                        res_status_next = qph_pkg::ST_NOT_FOUND;
                    end
                    else if (stat.occ && stat.key_match)
                    begin
                        res_slot_next = 1'b1;
                        if (stat.opcode == qph_pkg::OP_REMOVE)
                        begin
                            cmd.write_remove = 1'b1;
                            cmd.count_dec    = 1'b1;
                        end
                        else
                        begin
                            res_value_next = 1'b1;
                        end
                    end
                    else if (stat.exhausted)
                    begin
                        res_status_next = qph_pkg::ST_NOT_FOUND;
                    end
                    else
                    begin
                        state_next = qph_pkg::S_ADDR;
                    end
                end
            end
            qph_pkg::S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    cmd.count_clr = 1'b1;
                    state_next    = qph_pkg::S_RESULT;
                end
            end
            qph_pkg::S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = qph_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = qph_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[rtl/quadratic_probe_hash_table_core.sv]
// Top level of the quadratic probe hash table core.
`timescale 1ns / 1ps
// Open-addressing hash table of 64-bit keys and 64-bit values in TABLE_SLOTS slots.
// One word in gives one word out. After reset the flag memory is swept clear before the
// first word is taken; a clear sweeps it the same way. For lookup, insert and remove the
// home slot comes from a multiply, a residue fold and a reciprocal reduction, and each
// probe is one address, one registered memory read and one compare. An insert refused
// for the capacity register skips the hash and the probe walk. The result word sits in
// an output register, so the next word is taken while it waits.
module quadratic_probe_hash_table_core #(
    parameter int TABLE_SLOTS = 1021
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [9:0]   cfg_wr_data,    // capacity_limit
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // key [63:0], value [127:64]
    input  logic [1:0]   s_axis_tuser,   // opcode [1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [79:0]  m_axis_tdata,   // value_out [63:0], slot [73:64], zero [79:74]
    output logic [1:0]   m_axis_tuser    // status [1:0]
);

    qph_pkg::cmd_t  cmd;
    qph_pkg::stat_t stat;
    logic [63:0]    value_out;
    logic [9:0]     slot;

    qph_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    qph_datapath #(.TABLE_SLOTS(TABLE_SLOTS)) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_opcode  (s_axis_tuser),
        .in_key     (s_axis_tdata[63:0]),
        .in_value   (s_axis_tdata[127:64]),
        .cap_we     (cfg_wr_en),
        .cap_wdata  (cfg_wr_data),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_status (m_axis_tuser),
        .out_value  (value_out),
        .out_slot   (slot)
    );

    assign m_axis_tdata = {6'd0, slot, value_out};

endmodule

[verif/tb.sv]
// Self-checking testbench for the quadratic probe hash table core.
`timescale 1ns / 1ps
module tb;

    localparam int SLOTS = 1021;

    typedef struct packed {
        qph_pkg::op_t opcode;
        logic [63:0]  key;
        logic [63:0]  value;
    } req_t;

    typedef struct packed {
        qph_pkg::status_t status;
        logic [63:0]      value_out;
        logic [9:0]       slot;
    } rsp_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_wr_en;
    logic [9:0]   cfg_wr_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [79:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    quadratic_probe_hash_table_core dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    logic [63:0] tbl_key [SLOTS];
    logic [63:0] tbl_val [SLOTS];
    bit          tbl_occ [SLOTS];
    bit          tbl_tomb [SLOTS];
    int          tbl_count;
    int          cap_limit;

    req_t pending_q[$];
    rsp_t expected_q[$];
    logic [63:0] used_keys[$];
    int  errors;
    int  results_seen;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_cycles;
    int  n_by_op [4];
    int  n_by_status [4];
    bit  in_fired;

    function automatic int home_of(logic [63:0] k);
        logic [127:0] prod;
        prod = 128'(k) * 128'(536870909);
        return int'((prod[127:64] ^ prod[63:0]) % 64'(SLOTS));
    endfunction

    function automatic int probe_at(int home, int j);
        longint sq;
        longint off;
        sq = (longint'(j) * j) % SLOTS;
        off = (j & 1) ? sq : SLOTS - sq;
        return int'((home + off) % SLOTS);
    endfunction

    function automatic int find_key(logic [63:0] k);
        int h;
        int i;
        h = home_of(k);
        for (int j = 0; j < SLOTS; j++)
        begin
            i = probe_at(h, j);
            if (!tbl_occ[i] && !tbl_tomb[i])
                return -1;
            if (tbl_occ[i] && tbl_key[i] == k)
                return i;
        end
        return -1;
    endfunction

    function automatic int find_insert(logic [63:0] k);
        int h;
        int i;
        h = home_of(k);
        for (int j = 0; j < SLOTS; j++)
        begin
            i = probe_at(h, j);
            if (!tbl_occ[i] || tbl_key[i] == k)
                return i;
        end
        return -1;
    endfunction

    function automatic rsp_t predict_table_op(req_t r);
        rsp_t o;
        int i;
        o = '{qph_pkg::ST_OK, 64'd0, 10'd0};
        case (r.opcode)
            qph_pkg::OP_LOOKUP:
            begin
                i = find_key(r.key);
                if (i < 0)
                    o.status = qph_pkg::ST_NOT_FOUND;
                else
                begin
                    o.value_out = tbl_val[i];
                    o.slot = 10'(i);
                end
            end
            qph_pkg::OP_INSERT:
            begin
                if (tbl_count >= cap_limit)
                    o.status = qph_pkg::ST_NO_ROOM;
                else
                begin
                    i = find_insert(r.key);
                    if (i < 0)
                        o.status = qph_pkg::ST_NO_ROOM;
                    else if (tbl_occ[i])
                    begin
                        o.status = qph_pkg::ST_DUPLICATE;
                        o.slot = 10'(i);
                    end
                    else
                    begin
                        tbl_key[i] = r.key;
                        tbl_val[i] = r.value;
                        tbl_occ[i] = 1;
                        tbl_tomb[i] = 0;
                        tbl_count = (tbl_count + 1) & 1023;
                        o.slot = 10'(i);
                    end
                end
            end
            qph_pkg::OP_REMOVE:
            begin
                i = find_key(r.key);
                if (i < 0)
                    o.status = qph_pkg::ST_NOT_FOUND;
                else
                begin
                    tbl_occ[i] = 0;
                    tbl_tomb[i] = 1;
                    tbl_count = (tbl_count - 1) & 1023;
                    o.slot = 10'(i);
                end
            end
            default:
            begin
                for (int s = 0; s < SLOTS; s++)
                begin
                    tbl_occ[s] = 0;
                    tbl_tomb[s] = 0;
                end
                tbl_count = 0;
            end
        endcase
        return o;
    endfunction

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_axis_tvalid || in_fired)
            begin
                if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {pending_q[0].value, pending_q[0].key};
                    s_axis_tuser <= pending_q[0].opcode;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_cycles <= hold_cycles - 1;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        rsp_t got;
        rsp_t want;
        in_fired = rst_n && s_axis_tvalid && s_axis_tready;
        if (in_fired)
        begin
            expected_q.push_back(predict_table_op(pending_q[0]));
            n_by_op[pending_q[0].opcode]++;
            void'(pending_q.pop_front());
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = '{qph_pkg::status_t'(m_axis_tuser), m_axis_tdata[63:0], m_axis_tdata[73:64]};
            results_seen++;
            if (expected_q.size() == 0)
            begin
                $error("result word with nothing expected");
                errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                n_by_status[want.status]++;
                if (got.status != want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, got.status);
                    errors++;
                end
                if (got.value_out != want.value_out)
                begin
                    $error("value_out expected %h actual %h", want.value_out, got.value_out);
                    errors++;
                end
                if (got.slot != want.slot)
                begin
                    $error("slot expected %0d actual %0d", want.slot, got.slot);
                    errors++;
                end
                if (m_axis_tdata[79:74] != 6'd0)
                begin
                    $error("pad expected 0 actual %h", m_axis_tdata[79:74]);
                    errors++;
                end
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] pick_key();
        if (used_keys.size() > 0 && $urandom_range(99) < 70)
            return used_keys[$urandom_range(used_keys.size() - 1)];
        return rand64();
    endfunction

    task automatic add_op(qph_pkg::op_t op, logic [63:0] k, logic [63:0] v);
        pending_q.push_back('{op, k, v});
        if (op == qph_pkg::OP_INSERT && used_keys.size() < 400)
            used_keys.push_back(k);
    endtask

    task automatic drain();
        wait (pending_q.size() == 0 && !s_axis_tvalid);
        wait (expected_q.size() == 0);
        repeat (1200) @(posedge clk);
    endtask

    task automatic write_cap(int v);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= 10'(v);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        cap_limit = v;
    endtask

    task automatic random_burst(int n, int idle, int stall);
        qph_pkg::op_t op;
        int r;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            op = r < 45 ? qph_pkg::OP_INSERT : r < 75 ? qph_pkg::OP_LOOKUP :
                 r < 99 ? qph_pkg::OP_REMOVE : qph_pkg::OP_CLEAR;
            add_op(op, op == qph_pkg::OP_INSERT && $urandom_range(3) == 0 ? rand64() : pick_key(),
                   rand64());
        end
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        errors = 0;
        results_seen = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        tbl_count = 0;
        cap_limit = 714;
        for (int s = 0; s < SLOTS; s++)
        begin
            tbl_occ[s] = 0;
            tbl_tomb[s] = 0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        add_op(qph_pkg::OP_LOOKUP, 64'd0, 64'd0);
        add_op(qph_pkg::OP_REMOVE, 64'd0, 64'd0);
        add_op(qph_pkg::OP_INSERT, 64'd0, '1);
        add_op(qph_pkg::OP_INSERT, '1, 64'd0);
        add_op(qph_pkg::OP_INSERT, '1, 64'h5555_5555_5555_5555);
        add_op(qph_pkg::OP_LOOKUP, '1, 64'd0);
        add_op(qph_pkg::OP_LOOKUP, 64'd0, 64'd0);
        add_op(qph_pkg::OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 64'h1234);
        add_op(qph_pkg::OP_REMOVE, 64'd0, 64'd0);
        add_op(qph_pkg::OP_LOOKUP, 64'd0, 64'd0);
        add_op(qph_pkg::OP_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 64'd0);
        add_op(qph_pkg::OP_INSERT, 64'd0, 64'd7);
        add_op(qph_pkg::OP_REMOVE, 64'd0, '1);
        add_op(qph_pkg::OP_CLEAR, '1, '1);
        add_op(qph_pkg::OP_LOOKUP, '1, 64'd0);
        add_op(qph_pkg::OP_INSERT, 64'd1021, 64'd3);
        add_op(qph_pkg::OP_LOOKUP, 64'd1021, 64'd0);
        drain();

        write_cap(0);
        add_op(qph_pkg::OP_INSERT, 64'd42, 64'd1);
        add_op(qph_pkg::OP_LOOKUP, 64'd1021, 64'd0);
        drain();
        write_cap(1);
        add_op(qph_pkg::OP_INSERT, 64'd42, 64'd1);
        add_op(qph_pkg::OP_REMOVE, 64'd1021, 64'd0);
        add_op(qph_pkg::OP_INSERT, 64'd42, 64'd1);
        add_op(qph_pkg::OP_INSERT, 64'd43, 64'd1);
        drain();
        write_cap(714);

        random_burst(250, 0, 0);
        random_burst(250, 51, 0);
        random_burst(250, 0, 51);
        random_burst(250, 20, 20);

        // fill the receiver backlog while items keep coming
        for (int i = 0; i < 40; i++)
            add_op(qph_pkg::OP_LOOKUP, pick_key(), 64'd0);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 6000;
        drain();

        // raise the cap, add items, then run with small and large caps
        write_cap(1021);
        for (int i = 0; i < 40; i++)
            add_op(qph_pkg::OP_INSERT, rand64(), rand64());
        drain();
        write_cap(5);
        random_burst(60, 20, 20);
        write_cap(1023);
        add_op(qph_pkg::OP_CLEAR, 64'd0, 64'd0);
        random_burst(200, 10, 10);
        write_cap(714);
        random_burst(100, 0, 0);

        $display("covered ops lookup/insert/remove/clear: %0d/%0d/%0d/%0d, results %0d",
                 n_by_op[0], n_by_op[1], n_by_op[2], n_by_op[3], results_seen);
        $display("statuses ok/not_found/duplicate/no_room: %0d/%0d/%0d/%0d",
                 n_by_status[0], n_by_status[1], n_by_status[2], n_by_status[3]);
        if (errors == 0)
            $display("PASS quadratic_probe_hash_table_core");
        else
            $display("FAIL quadratic_probe_hash_table_core");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("FAIL quadratic_probe_hash_table_core");
        $finish;
    end
endmodule
